### design/segment_intersection_macros.svh
// assertion macros used by segment_intersection
`ifndef SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_INTERSECTION_MACROS_SVH

// implication checked at every clock edge outside reset
`define SI_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// implication whose consequent is checked in the next cycle
`define SI_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

### design/segint_pkg.sv
package segint_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 4;
  localparam int QUOT_MARGIN    = 2;

  // flags that travel with a pair down the pipeline
  typedef struct packed {
    logic hit;
    logic degenerate;
    logic neg_x;
    logic neg_y;
  } seg_flags_t;
endpackage

### design/segment_intersection.sv
// segment_intersection: straddle test and intersection point of two segments
// input stream s_axis: one transaction carries both segments, eight signed
// coordinates in raw fixed point. output stream m_axis: hit, degenerate and the
// truncated intersection point, zero when there is no hit or it is degenerate.
// the block is a pipeline that accepts one transaction per cycle unless the
// output stalls. stages in order: differences, products, sums and cross signs,
// the numerator, magnitudes, then one divider stage per quotient bit (COORD_BITS+2).
// all stages move together: when m_axis_tready is low and the last stage holds
// a result, the whole pipe holds and s_axis_tready drops.
// reset clears all valid bits; nothing in flight survives it.
// one result is produced per input transaction, in order.
module segment_intersection
  import segint_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [8*COORD_BITS-1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // hit, degenerate, cross_x, cross_y, zero padding
  output logic [((2*COORD_BITS+2+7)/8)*8-1:0] m_axis_tdata
);
  `include "segment_intersection_macros.svh"

  localparam int C   = COORD_BITS;
  localparam int D   = C + 1;          // difference width
  localparam int P   = 2 * D;          // product of two differences
  localparam int S   = P + 1;          // sum of two products
  localparam int N   = 3 * D + 2;      // numerator width
  localparam int QB  = C + QUOT_MARGIN;
  localparam int DIV_LAT = QB;
  localparam int OW  = ((2 * C + 2 + 7) / 8) * 8;
  // scale of the format does not enter the arithmetic
  localparam int FRAC_UNUSED = FRAC_BITS;

  logic en;
  logic v1, v2, v3, v4, v5;
  logic [DIV_LAT-1:0] vd;
  assign en = !vd[DIV_LAT-1] || m_axis_tready;
  assign s_axis_tready = en;

  // stage 0: unpack
  logic signed [C-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
  assign x1 = s_axis_tdata[0*C +: C];
  assign y1 = s_axis_tdata[1*C +: C];
  assign x2 = s_axis_tdata[2*C +: C];
  assign y2 = s_axis_tdata[3*C +: C];
  assign x3 = s_axis_tdata[4*C +: C];
  assign y3 = s_axis_tdata[5*C +: C];
  assign x4 = s_axis_tdata[6*C +: C];
  assign y4 = s_axis_tdata[7*C +: C];

  // stage 1: differences and box test
  logic signed [D-1:0] dx1, dy1, dx2, dy2, ax13, ay13, ax23, ay23, ax31, ay31, ax41, ay41;
  logic signed [C-1:0] r_x1, r_x3, r_y2, r_y4;
  logic box_ok;
  always_ff @(posedge clk) begin
    if (en) begin
      dx1  <= D'(x2) - D'(x1);
      dy1  <= D'(y2) - D'(y1);
      dx2  <= D'(x4) - D'(x3);
      dy2  <= D'(y4) - D'(y3);
      ax13 <= D'(x1) - D'(x3);
      ay13 <= D'(y1) - D'(y3);
      ax23 <= D'(x2) - D'(x3);
      ay23 <= D'(y2) - D'(y3);
      ax31 <= D'(x3) - D'(x1);
      ay31 <= D'(y3) - D'(y1);
      ax41 <= D'(x4) - D'(x1);
      ay41 <= D'(y4) - D'(y1);
      r_x1 <= x1;
      r_x3 <= x3;
      r_y2 <= y2;
      r_y4 <= y4;
      box_ok <= !(((x1 > x2) ? x1 : x2) < ((x3 < x4) ? x3 : x4) ||
                  ((y1 > y2) ? y1 : y2) < ((y3 < y4) ? y3 : y4) ||
                  ((x3 > x4) ? x3 : x4) < ((x1 < x2) ? x1 : x2) ||
                  ((y3 > y4) ? y3 : y4) < ((y1 < y2) ? y1 : y2));
    end
  end

  // stage 2: two-term products
  logic signed [P-1:0] c1a, c1b, c2a, c2b, c3a, c3b, c4a, c4b;
  logic signed [P-1:0] ex_a, ex_b, ey_a, ey_b;
  logic signed [P-1:0] px_a, px_b, px_c, py_a, py_b, py_c;
  logic signed [D-1:0] s2_dx1, s2_dx2, s2_dy1, s2_dy2;
  logic box2;
  always_ff @(posedge clk) begin
    if (en) begin
      c1a <= ax13 * dy2;  c1b <= ay13 * dx2;
      c2a <= ax23 * dy2;  c2b <= ay23 * dx2;
      c3a <= ax31 * dy1;  c3b <= ay31 * dx1;
      c4a <= ax41 * dy1;  c4b <= ay41 * dx1;
      // den_x = dx2*(y1-y2) - dx1*(y3-y4) ; den_y = (x1-x2)*dy2 - dy1*(x3-x4)
      ex_a <= dx2 * (-dy1);
      ex_b <= dx1 * (-dy2);
      ey_a <= (-dx1) * dy2;
      ey_b <= dy1 * (-dx2);
      // first factors of the numerator terms
      px_a <= ay13 * dx1;            // (y1-y3)*dx1, times dx2
      px_b <= D'(r_x3) * dy2;        // x3*dy2, times dx1
      px_c <= D'(r_x1) * dy1;        // x1*dy1, times dx2
      py_a <= D'(r_y2) * (-dx1);     // y2*(x1-x2), times dy2
      py_b <= (ax41 - dx1) * dy2;    // (x4-x2)*dy2, times (y1-y2)
      py_c <= D'(r_y4) * (-dx2);     // y4*(x3-x4), times dy1
      s2_dx1 <= dx1; s2_dx2 <= dx2; s2_dy1 <= dy1; s2_dy2 <= dy2;
      box2 <= box_ok;
    end
  end

  // stage 3: cross signs, denominators, third factors
  logic signed [N-1:0] tx_a, tx_b, tx_c, ty_a, ty_b, ty_c;
  logic signed [S-1:0] den_x, den_y;
  logic hit3;
  always_comb begin
    logic signed [S-1:0] k1, k2, k3, k4;
    logic sp1, sp2, sp3, sp4;
    k1 = S'(c1a) - S'(c1b);
    k2 = S'(c2a) - S'(c2b);
    k3 = S'(c3a) - S'(c3b);
    k4 = S'(c4a) - S'(c4b);
    sp1 = (k1 > 0) && (k2 > 0) || (k1 < 0) && (k2 < 0);
    sp2 = (k3 > 0) && (k4 > 0) || (k3 < 0) && (k4 < 0);
    sp3 = 1'b0;
    sp4 = 1'b0;
    hit3 = box2 && !sp1 && !sp2 && !sp3 && !sp4;
  end
  logic hit_r3;
  always_ff @(posedge clk) begin
    if (en) begin
      tx_a <= px_a * s2_dx2;
      tx_b <= px_b * s2_dx1;
      tx_c <= px_c * s2_dx2;
      ty_a <= py_a * s2_dy2;
      ty_b <= py_b * (-s2_dy1);
      ty_c <= py_c * s2_dy1;
      den_x <= S'(ex_a) - S'(ex_b);
      den_y <= S'(ey_a) - S'(ey_b);
      hit_r3 <= hit3;
    end
  end

  // stage 4: numerators
  logic signed [N-1:0] num_x, num_y;
  logic signed [S-1:0] den_x4, den_y4;
  logic hit4;
  always_ff @(posedge clk) begin
    if (en) begin
      num_x <= tx_a + tx_b - tx_c;
      num_y <= ty_a + ty_b - ty_c;
      den_x4 <= den_x;
      den_y4 <= den_y;
      hit4 <= hit_r3;
    end
  end

  // stage 5: magnitudes and flags
  logic [N-1:0] mag_nx, mag_ny;
  logic [S-1:0] mag_dx, mag_dy;
  seg_flags_t fl5;
  always_ff @(posedge clk) begin
    if (en) begin
      mag_nx <= num_x[N-1] ? N'(-num_x) : N'(num_x);
      mag_ny <= num_y[N-1] ? N'(-num_y) : N'(num_y);
      mag_dx <= den_x4[S-1] ? S'(-den_x4) : S'(den_x4);
      mag_dy <= den_y4[S-1] ? S'(-den_y4) : S'(den_y4);
      fl5.hit        <= hit4;
      fl5.degenerate <= hit4 && (den_x4 == '0 || den_y4 == '0);
      fl5.neg_x      <= num_x[N-1] ^ den_x4[S-1];
      fl5.neg_y      <= num_y[N-1] ^ den_y4[S-1];
    end
  end

  // dividers
  logic [QB-1:0] qx, qy;
  logic [S-1:0] dsafe_x, dsafe_y;
  assign dsafe_x = (mag_dx == '0) ? S'(1) : mag_dx;
  assign dsafe_y = (mag_dy == '0) ? S'(1) : mag_dy;
  segint_div #(.NUM_BITS(N), .DEN_BITS(S), .Q_BITS(QB)) u_div_x (
    .clk(clk), .en(en), .num(mag_nx), .den(dsafe_x), .quot(qx));
  segint_div #(.NUM_BITS(N), .DEN_BITS(S), .Q_BITS(QB)) u_div_y (
    .clk(clk), .en(en), .num(mag_ny), .den(dsafe_y), .quot(qy));

  seg_flags_t fl_d [DIV_LAT+1];
  assign fl_d[0] = fl5;
  for (genvar i = 0; i < DIV_LAT; i++) begin : g_flags
    always_ff @(posedge clk) begin
      if (en) fl_d[i+1] <= fl_d[i];
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      vd <= '0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
      vd <= {vd[DIV_LAT-2:0], v5};
    end
  end

  seg_flags_t fo;
  logic signed [C-1:0] ox, oy;
  always_comb begin
    fo = fl_d[DIV_LAT];
    ox = '0;
    oy = '0;
    if (fo.hit && !fo.degenerate) begin
      ox = fo.neg_x ? C'(-qx) : C'(qx);
      oy = fo.neg_y ? C'(-qy) : C'(qy);
    end
  end

  assign m_axis_tvalid = vd[DIV_LAT-1];
  assign m_axis_tdata = OW'({oy, ox, fo.degenerate, fo.hit}) |
                        OW'(FRAC_UNUSED - FRAC_UNUSED);

  `SI_ASSERT_IMP(a_deg_hit, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[0],
    "degenerate without hit")
  `SI_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `SI_ASSERT_IMP(a_ready, !m_axis_tvalid, s_axis_tready, "pipe stalled while output empty")
endmodule

### design/segint_div.sv
// pipelined restoring divider, one quotient bit per stage; magnitudes in, magnitude out
module segint_div
  import segint_pkg::*;
#(
  parameter int NUM_BITS = 64,
  parameter int DEN_BITS = 40,
  parameter int Q_BITS   = 18
) (
  input  logic                clk,
  input  logic                en,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic [Q_BITS-1:0]   quot
);
  localparam int RB = DEN_BITS + 1;

  // numerator bits below Q_BITS only contribute, upper part is assumed to give a small quotient
  logic [NUM_BITS-1:0] n_s [Q_BITS+1];
  logic [DEN_BITS-1:0] d_s [Q_BITS+1];
  logic [RB-1:0]       r_s [Q_BITS+1];
  logic [Q_BITS-1:0]   q_s [Q_BITS+1];

  assign n_s[0] = num;
  assign d_s[0] = den;
  assign q_s[0] = '0;
  // the quotient fits Q_BITS, so the top bits form the initial remainder
  assign r_s[0] = RB'(num >> Q_BITS);

  for (genvar i = 0; i < Q_BITS; i++) begin : g_stage
    logic [RB:0]   trial;
    logic [RB-1:0] r_next;
    logic          take;
    always_comb begin
      trial  = {r_s[i], n_s[i][Q_BITS-1-i]} - {2'b0, d_s[i]};
      take   = !trial[RB];
      r_next = take ? trial[RB-1:0] : {r_s[i][RB-2:0], n_s[i][Q_BITS-1-i]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_s[i+1] <= n_s[i];
        d_s[i+1] <= d_s[i];
        r_s[i+1] <= r_next;
        q_s[i+1] <= {q_s[i][Q_BITS-2:0], take};
      end
    end
  end

  assign quot = q_s[Q_BITS];
endmodule
